/* rtl/drfh_pkg.sv */
// ----------------------------------------------------------------------------
// drfh_pkg
// Shared types and codes for the request FIFO with duplicate rejection and
// history stack.
// ----------------------------------------------------------------------------
`default_nettype none

package drfh_pkg;

	localparam int ID_W      = 32;
	localparam int PAY_W     = 64;
	localparam int STATUS_W  = 3;
	localparam int QCOUNT_W  = 5;
	localparam int HCOUNT_W  = 7;

	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_QFULL  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_QEMPTY = 3'd3;
	localparam logic [STATUS_W-1:0] ST_HFULL  = 3'd4;

	typedef struct packed {
		logic             action;
		logic [ID_W-1:0]  id;
		logic [PAY_W-1:0] payload;
	} cmd_t;

	typedef struct packed {
		logic [HCOUNT_W-1:0] history_count;
		logic [QCOUNT_W-1:0] queued_count;
		logic [PAY_W-1:0]    removed_payload;
		logic [ID_W-1:0]     removed_id;
		logic                accepted;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

`default_nettype wire

/* rtl/drfh_ram.sv */
// ----------------------------------------------------------------------------
// drfh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module drfh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/drfh_front.sv */
// ----------------------------------------------------------------------------
// drfh_front
// Accepts input words, classifies them into commands and holds them in a
// two-entry command queue ahead of the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none

module drfh_front import drfh_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        in_action,
	input  wire logic [95:0] in_data,
	output logic             cmd_valid,
	input  wire logic        cmd_ready,
	output cmd_t             cmd
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	cmd_t       in_cmd;

	always_comb begin
		in_cmd.action  = (in_action == ACT_DEQ) ? ACT_DEQ : ACT_ENQ;
		in_cmd.id      = in_data[ID_W-1:0];
		in_cmd.payload = in_data[ID_W+PAY_W-1:ID_W];
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/drfh_back.sv */
// ----------------------------------------------------------------------------
// drfh_back
// Execution engine: scans the queue memory for duplicate keys, enqueues and
// dequeues entries, pushes dequeued entries onto the history and registers
// one result word per command.
// ----------------------------------------------------------------------------
`default_nettype none

module drfh_back import drfh_pkg::*; #(
	parameter int QUEUE_DEPTH   = 16,
	parameter int HISTORY_DEPTH = 64,
	parameter int KEY_BITS      = 32,
	parameter int PAYLOAD_BITS  = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	input  wire cmd_t cmd,
	output logic      res_valid,
	input  wire logic res_ready,
	output res_t      res
);

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int HAW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int HCW = $clog2(HISTORY_DEPTH + 1);
	localparam int EW  = KEY_BITS + PAYLOAD_BITS;

	localparam logic [QAW-1:0] QLAST = QAW'(QUEUE_DEPTH - 1);
	localparam logic [QCW-1:0] QFULL = QCW'(QUEUE_DEPTH);
	localparam logic [HCW-1:0] HFULL = HCW'(HISTORY_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]              state_q;
	logic                    act_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [QAW-1:0]          head_q;
	logic [QAW-1:0]          tail_q;
	logic [QCW-1:0]          fill_q;
	logic [HCW-1:0]          hfill_q;
	logic [QAW-1:0]          ptr_q;
	logic [QCW-1:0]          iss_q;
	logic                    cmp_vld_q;
	logic                    dup_q;
	res_t                    res_q;
	logic                    res_valid_q;

	logic           start;
	logic           out_free;
	logic           fin;
	logic           q_rd_en;
	logic [QAW-1:0] q_rd_addr;
	logic [EW-1:0]  q_rd_data;
	logic           q_wr_en;
	logic           h_wr_en;
	logic           scan_issue;
	logic           key_match;
	logic [QAW-1:0] head_nxt;
	logic [QAW-1:0] tail_nxt;
	logic [QAW-1:0] ptr_nxt;
	logic [STATUS_W-1:0] fin_status;
	logic [QCW-1:0] fill_nxt;
	logic [HCW-1:0] hfill_nxt;
	res_t           res_nxt;

	assign cmd_ready = (state_q == S_IDLE);
	assign start     = cmd_valid && cmd_ready;
	assign out_free  = !res_valid_q || res_ready;
	assign fin       = (state_q == S_FIN) && out_free;

	assign head_nxt = (head_q == QLAST) ? '0 : head_q + QAW'(1);
	assign tail_nxt = (tail_q == QLAST) ? '0 : tail_q + QAW'(1);
	assign ptr_nxt  = (ptr_q == QLAST) ? '0 : ptr_q + QAW'(1);

	assign scan_issue = (state_q == S_SCAN) && (iss_q != fill_q);
	assign q_rd_en    = (start && (fill_q != '0)) || scan_issue;
	assign q_rd_addr  = (state_q == S_IDLE) ? head_q : ptr_q;
	assign key_match  = (q_rd_data[KEY_BITS-1:0] == key_q);

	always_comb begin
		fin_status = ST_OK;
		if (act_q == ACT_ENQ) begin
			if (dup_q) begin
				fin_status = ST_DUP;
			end else if (fill_q == QFULL) begin
				fin_status = ST_QFULL;
			end
		end else begin
			if (fill_q == '0) begin
				fin_status = ST_QEMPTY;
			end else if (hfill_q == HFULL) begin
				fin_status = ST_HFULL;
			end
		end
	end

	always_comb begin
		fill_nxt         = fill_q;
		hfill_nxt        = hfill_q;
		res_nxt          = '0;
		res_nxt.status   = fin_status;
		res_nxt.accepted = (fin_status == ST_OK);
		if ((act_q == ACT_ENQ) && (fin_status == ST_OK)) begin
			fill_nxt = fill_q + QCW'(1);
		end
		if ((act_q == ACT_DEQ) && (fin_status != ST_QEMPTY)) begin
			fill_nxt                = fill_q - QCW'(1);
			res_nxt.removed_id      = ID_W'(q_rd_data[KEY_BITS-1:0]);
			res_nxt.removed_payload = PAY_W'(q_rd_data[EW-1:KEY_BITS]);
		end
		if ((act_q == ACT_DEQ) && (fin_status == ST_OK)) begin
			hfill_nxt = hfill_q + HCW'(1);
		end
		res_nxt.queued_count  = QCOUNT_W'(fill_nxt);
		res_nxt.history_count = HCOUNT_W'(hfill_nxt);
	end

	assign q_wr_en = fin && (act_q == ACT_ENQ) && (fin_status == ST_OK);
	assign h_wr_en = fin && (act_q == ACT_DEQ) && (fin_status == ST_OK);

	drfh_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue_ram (
		.clk     (clk),
		.wr_en   (q_wr_en),
		.wr_addr (tail_q),
		.wr_data ({pay_q, key_q}),
		.rd_en   (q_rd_en),
		.rd_addr (q_rd_addr),
		.rd_data (q_rd_data)
	);

	drfh_ram #(
		.WIDTH (EW),
		.DEPTH (HISTORY_DEPTH)
	) u_history_ram (
		.clk     (clk),
		.wr_en   (h_wr_en),
		.wr_addr (hfill_q[HAW-1:0]),
		.wr_data (q_rd_data),
		.rd_en   (1'b0),
		.rd_addr ('0),
		.rd_data ()
	);

	always_ff @(posedge clk) begin
		if (start) begin
			act_q <= cmd.action;
			key_q <= KEY_BITS'(cmd.id);
			pay_q <= PAYLOAD_BITS'(cmd.payload);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			hfill_q     <= '0;
			ptr_q       <= '0;
			iss_q       <= '0;
			cmp_vld_q   <= 1'b0;
			dup_q       <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (fin) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						dup_q     <= 1'b0;
						ptr_q     <= head_nxt;
						iss_q     <= QCW'(1);
						cmp_vld_q <= (fill_q != '0);
						if ((cmd.action == ACT_ENQ) && (fill_q != '0)) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					if (cmp_vld_q && key_match) begin
						dup_q <= 1'b1;
					end
					if (scan_issue) begin
						ptr_q <= ptr_nxt;
						iss_q <= iss_q + QCW'(1);
					end
					cmp_vld_q <= scan_issue;
					if (!scan_issue && cmp_vld_q) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						res_q   <= res_nxt;
						fill_q  <= fill_nxt;
						hfill_q <= hfill_nxt;
						if (fin_status == ST_OK && act_q == ACT_ENQ) begin
							tail_q <= tail_nxt;
						end
						if (act_q == ACT_DEQ && fin_status != ST_QEMPTY) begin
							head_q <= head_nxt;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

/* rtl/dedup_request_fifo_with_history.sv */
// ----------------------------------------------------------------------------
// dedup_request_fifo_with_history
// Request FIFO that refuses duplicate keys and keeps a history stack of
// dequeued entries.
// ----------------------------------------------------------------------------
//
// Channel  Dir  tdata (low bit first)                      tuser
// s_axis   in   request_id[31:0], request_payload[63:0]    action
// m_axis   out  status, accepted, removed_id, removed_payload,
//               queued_count, history_count                 -
//
// An enqueue into a non-empty queue first scans every queued key for a duplicate:
// the duplicate scan reads one queued key per cycle from the queue RAM's read port.
// A dequeue or an enqueue into an empty queue goes straight to the finish state.
// A two-entry command queue sits in front of the engine, and the result word
// is registered, so input words are taken while a result waits.
// Reset clears all pointers and counts; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_request_fifo_with_history import drfh_pkg::*; #(
	parameter int QUEUE_DEPTH   = 16,
	parameter int HISTORY_DEPTH = 64,
	parameter int KEY_BITS      = 32,
	parameter int PAYLOAD_BITS  = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// request_id[31:0], request_payload[95:32]
	input  wire logic [95:0]  s_axis_tdata,
	// action
	input  wire logic         s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// status[2:0], accepted[3], removed_id[35:4], removed_payload[99:36],
	// queued_count[104:100], history_count[111:105]
	output logic      [111:0] m_axis_tdata
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	res_t res;

	drfh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	drfh_back #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.KEY_BITS      (KEY_BITS),
		.PAYLOAD_BITS  (PAYLOAD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = res;

endmodule

`default_nettype wire

/* sim/drfh_checker.sv */
// ----------------------------------------------------------------------------
// drfh_checker
// Watches both stream channels of the deduplicating request FIFO. It keeps
// its own queue, history fill and pointers, works out the result word that
// each accepted request word must produce, and compares every result word
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module drfh_checker import drfh_pkg::*; #(
	parameter int QUEUE_DEPTH   = 16,
	parameter int HISTORY_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	// request_id[31:0], request_payload[95:32]
	input  logic [95:0]  s_axis_tdata,
	// action
	input  logic         s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[2:0], accepted[3], removed_id[35:4], removed_payload[99:36],
	// queued_count[104:100], history_count[111:105]
	input  logic [111:0] m_axis_tdata,
	output int           errors,
	output int           results_pending
);

	logic [ID_W-1:0]  fifo_keys [QUEUE_DEPTH];
	logic [PAY_W-1:0] fifo_data [QUEUE_DEPTH];
	logic [ID_W-1:0]  hist_keys [HISTORY_DEPTH];
	logic [PAY_W-1:0] hist_data [HISTORY_DEPTH];
	int               rd_ptr;
	int               wr_ptr;
	int               fifo_fill;
	int               hist_fill;
	res_t             awaited_results [$];

	function automatic int wrap_inc(int ptr);
		return (ptr == QUEUE_DEPTH - 1) ? 0 : ptr + 1;
	endfunction

	function automatic res_t predict_request(logic act, logic [ID_W-1:0] id,
			logic [PAY_W-1:0] pay);
		res_t r;
		logic dup;
		int   idx;
		r = '0;
		r.status = ST_OK;
		if (act == ACT_ENQ) begin
			dup = 1'b0;
			idx = rd_ptr;
			for (int i = 0; i < fifo_fill; i++) begin
				if (fifo_keys[idx] == id)
					dup = 1'b1;
				idx = wrap_inc(idx);
			end
			if (dup) begin
				r.status = ST_DUP;
			end else if (fifo_fill >= QUEUE_DEPTH) begin
				r.status = ST_QFULL;
			end else begin
				fifo_keys[wr_ptr] = id;
				fifo_data[wr_ptr] = pay;
				wr_ptr = wrap_inc(wr_ptr);
				fifo_fill++;
			end
		end else begin
			if (fifo_fill == 0) begin
				r.status = ST_QEMPTY;
			end else begin
				r.removed_id      = fifo_keys[rd_ptr];
				r.removed_payload = fifo_data[rd_ptr];
				rd_ptr = wrap_inc(rd_ptr);
				fifo_fill--;
				// A full history drops the entry after taking it off the queue.
				if (hist_fill >= HISTORY_DEPTH) begin
					r.status = ST_HFULL;
				end else begin
					hist_keys[hist_fill] = r.removed_id;
					hist_data[hist_fill] = r.removed_payload;
					hist_fill++;
				end
			end
		end
		r.accepted      = (r.status == ST_OK);
		r.queued_count  = QCOUNT_W'(fifo_fill);
		r.history_count = HCOUNT_W'(hist_fill);
		return r;
	endfunction

	task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			rd_ptr = 0;
			wr_ptr = 0;
			fifo_fill = 0;
			hist_fill = 0;
			errors = 0;
			awaited_results.delete();
			results_pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word: expected none, got %h",
						$time, m_axis_tdata);
				end else begin
					want = awaited_results.pop_front();
					got  = res_t'(m_axis_tdata);
					compare_field("status", 64'(want.status), 64'(got.status));
					compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
					compare_field("removed_id", 64'(want.removed_id), 64'(got.removed_id));
					compare_field("removed_payload", want.removed_payload,
						got.removed_payload);
					compare_field("queued_count", 64'(want.queued_count),
						64'(got.queued_count));
					compare_field("history_count", 64'(want.history_count),
						64'(got.history_count));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				awaited_results.push_back(predict_request(s_axis_tuser,
					s_axis_tdata[31:0], s_axis_tdata[95:32]));
			results_pending = awaited_results.size();
		end
	end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives enqueue and dequeue words into the deduplicating request FIFO:
// a directed opening covering empty, duplicate, full and extreme values,
// then random traffic with a small key pool so that duplicates, a full queue
// and a full history all occur. Both channels stall at random in the first
// two of three phases, and a separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import drfh_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [95:0]  s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [111:0] m_axis_tdata;
	int           errors;
	int           results_pending;
	int           rx_idle_pct = 74;
	int           idle_cycles = 0;
	logic [31:0]  id_salt;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	dedup_request_fifo_with_history dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	drfh_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.errors          (errors),
		.results_pending (results_pending)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_word(logic act, logic [ID_W-1:0] id, logic [PAY_W-1:0] pay);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {pay, id};
		@(negedge clk);
		while (!s_axis_tready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (results_pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic random_phase(int count, int tx_idle_pct, int rx_pct);
		logic             act;
		logic [ID_W-1:0]  id;
		logic [PAY_W-1:0] pay;
		int               deq_pct;
		int               pick;
		rx_idle_pct <= rx_pct;
		deq_pct = 40;
		for (int k = 0; k < count; k++) begin
			// Every 50 words, pick filling or draining at random so the fill swings widely.
			if (k % 50 == 0)
				deq_pct = $urandom_range(0, 1) ? 25 : 60;
			if ($urandom_range(0, 99) < tx_idle_pct) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
			act = ($urandom_range(0, 99) < deq_pct) ? ACT_DEQ : ACT_ENQ;
			id  = ($urandom_range(0, 9) < 7) ? (id_salt ^ $urandom_range(0, 23)) : $urandom;
			pick = $urandom_range(0, 19);
			if (pick == 0)
				pay = '0;
			else if (pick == 1)
				pay = '1;
			else
				pay = {$urandom, $urandom};
			send_word(act, id, pay);
		end
	endtask

	initial begin
		id_salt = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(ACT_DEQ, $urandom, {$urandom, $urandom});
		send_word(ACT_ENQ, 32'h0, 64'h0);
		send_word(ACT_ENQ, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(ACT_ENQ, 32'h0, {$urandom, $urandom});
		send_word(ACT_DEQ, 32'h0, 64'h0);
		send_word(ACT_DEQ, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(ACT_DEQ, 32'h0, 64'h0);
		for (int i = 0; i < 16; i++)
			send_word(ACT_ENQ, 32'h1 << (2 * i), {$urandom, $urandom});
		send_word(ACT_ENQ, 32'h5555_AAAA, {$urandom, $urandom});
		send_word(ACT_ENQ, 32'h1, {$urandom, $urandom});
		send_word(ACT_DEQ, 32'h0, 64'h0);
		wait_for_results();

		random_phase(700, 15, 74);
		wait_for_results();
		random_phase(700, 74, 15);
		wait_for_results();
		random_phase(600, 0, 0);
		wait_for_results();
		repeat (40) @(posedge clk);

		if (errors == 0 && results_pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* dedup_request_fifo_with_history.f */
rtl/drfh_pkg.sv
rtl/drfh_ram.sv
rtl/drfh_front.sv
rtl/drfh_back.sv
rtl/dedup_request_fifo_with_history.sv
sim/drfh_checker.sv
sim/testbench.sv
